FILE: rtl/core/jcsd_pkg.sv
// Shared types, constants and codes for the joystick centre/scale/direction block.
package jcsd_pkg;

  // Sample and result field widths
  localparam int RAW_W = 8;
  localparam int PCT_W = 8;
  localparam int DIR_W = 3;
  localparam int THR_W = 7;

  // Calibration run length and the accumulator widths that follow from it
  localparam int CALIB_SAMPLES = 32;
  localparam int CNT_W = (CALIB_SAMPLES > 2) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int SUM_W = RAW_W + $clog2(CALIB_SAMPLES);

  // Scaling: dividend is 100 * |raw - centre|, at most 25500
  localparam int PCT_FULL  = 100;
  localparam int NUM_W     = 15;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int AXES      = 2;

  // Register reset values
  localparam logic [RAW_W-1:0] UPPER_RST  = 8'd245;
  localparam logic [RAW_W-1:0] LOWER_RST  = 8'd75;
  localparam logic [THR_W-1:0] THRESH_RST = 7'd40;
  localparam logic [RAW_W-1:0] CENTRE_RST = 8'd160;

  // Configuration bus
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_UPPER  = 2'd0,
    REG_LOWER  = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  // Item kinds
  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_POS   = 1'b1;

  typedef enum logic [DIR_W-1:0] {
    STICK_NEUTRAL = 3'd0,
    STICK_UP      = 3'd1,
    STICK_DOWN    = 3'd2,
    STICK_RIGHT   = 3'd3,
    STICK_LEFT    = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BRANCH,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] upper_limit;
    logic [RAW_W-1:0] lower_limit;
    logic [THR_W-1:0] direction_threshold;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calib_step;
    logic setup;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;
  } dp_status_t;

endpackage

FILE: rtl/core/jcsd_if.sv
// Sample and result channel interfaces for the joystick conditioner.
interface jcsd_in_if;
  import jcsd_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;

  modport source(output valid, kind, raw_x, raw_y, input ready);
  modport sink(input valid, kind, raw_x, raw_y, output ready);
endinterface

interface jcsd_out_if;
  import jcsd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] x_pct;
  logic signed [PCT_W-1:0] y_pct;
  logic [DIR_W-1:0]        direction;
  logic                    centre_latched;

  modport source(output valid, x_pct, y_pct, direction, centre_latched, input ready);
  modport sink(input valid, x_pct, y_pct, direction, centre_latched, output ready);
endinterface

FILE: rtl/core/jcsd_regs.sv
// APB configuration registers: limits and direction threshold.
module jcsd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [jcsd_pkg::DATA_W-1:0]   pwdata,
  output logic [jcsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output jcsd_pkg::cfg_t                cfg
);
  import jcsd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_limit         <= UPPER_RST;
      cfg.lower_limit         <= LOWER_RST;
      cfg.direction_threshold <= THRESH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_UPPER:  cfg.upper_limit         <= pwdata[RAW_W-1:0];
        REG_LOWER:  cfg.lower_limit         <= pwdata[RAW_W-1:0];
        REG_THRESH: cfg.direction_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_UPPER:  prdata = DATA_W'(cfg.upper_limit);
      REG_LOWER:  prdata = DATA_W'(cfg.lower_limit);
      REG_THRESH: prdata = DATA_W'(cfg.direction_threshold);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/jcsd_ctrl.sv
// Controller: sequences capture, calibration, division and result load.
module jcsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  jcsd_pkg::dp_status_t status,
  output jcsd_pkg::dp_cmd_t    cmd
);
  import jcsd_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign out_free = ~out_valid | out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_BRANCH;
      ST_BRANCH: state_next = (status.kind == KIND_CALIB) ? ST_FINISH : ST_DIV;
      ST_DIV:    if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.capture    = (state == ST_IDLE) & in_valid;
    cmd.calib_step = (state == ST_BRANCH) & (status.kind == KIND_CALIB);
    cmd.setup      = (state == ST_BRANCH) & (status.kind == KIND_POS);
    cmd.div_step   = (state == ST_DIV);
    cmd.load_out   = (state == ST_FINISH) & out_free;
  end

  // State, step count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/jcsd_datapath.sv
// Datapath: calibration accumulators, per-axis dividers, classifier, result register.
module jcsd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  jcsd_pkg::dp_cmd_t                   cmd,
  output jcsd_pkg::dp_status_t                status,
  input  jcsd_pkg::cfg_t                      cfg,
  input  logic                                kind,
  input  logic [jcsd_pkg::RAW_W-1:0]          raw_x,
  input  logic [jcsd_pkg::RAW_W-1:0]          raw_y,
  output logic signed [jcsd_pkg::PCT_W-1:0]   x_pct,
  output logic signed [jcsd_pkg::PCT_W-1:0]   y_pct,
  output logic [jcsd_pkg::DIR_W-1:0]          direction,
  output logic                                centre_latched
);
  import jcsd_pkg::*;

  // Captured transaction
  logic             kind_q;
  logic [RAW_W-1:0] raw_q [AXES];

  // Calibration state
  logic [SUM_W-1:0] sum_acc [AXES];
  logic [CNT_W-1:0] calib_count;
  logic [RAW_W-1:0] centre [AXES];
  logic             latched_q;

  // Division lanes
  logic             above_q     [AXES];
  logic             diff_zero_q [AXES];
  logic             den_zero_q  [AXES];
  logic             den_neg_q   [AXES];
  logic [RAW_W-1:0] den_mag_q   [AXES];
  logic [RAW_W-1:0] rem_q       [AXES];
  logic [NUM_W-1:0] quo_q       [AXES];

  // Setup terms
  logic             s_above     [AXES];
  logic [RAW_W-1:0] s_diff      [AXES];
  logic [RAW_W-1:0] s_lim       [AXES];
  logic             s_den_neg   [AXES];
  logic [RAW_W-1:0] s_den_mag   [AXES];
  logic [NUM_W-1:0] s_num       [AXES];

  // Division step terms
  logic [RAW_W:0]   d_shift     [AXES];
  logic             d_fits      [AXES];

  // Calibration terms
  logic [SUM_W-1:0] sum_new     [AXES];
  logic             run_done;

  // Percent and direction
  logic signed [PCT_W-1:0] pct   [AXES];
  logic signed [PCT_W-1:0] pmag  [AXES];
  logic [PCT_W-2:0]        qclip [AXES];
  logic signed [PCT_W-1:0] thr_pos;
  logic signed [PCT_W-1:0] thr_neg;
  dir_t                    dir_c;

  assign status.kind = kind_q;
  assign run_done    = (calib_count == CNT_W'(CALIB_SAMPLES - 1));

  // Form numerator, divisor magnitude and sign for each axis
  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      s_above[l]   = raw_q[l] > centre[l];
      s_diff[l]    = s_above[l] ? (raw_q[l] - centre[l]) : (centre[l] - raw_q[l]);
      s_lim[l]     = s_above[l] ? cfg.upper_limit : cfg.lower_limit;
      s_den_neg[l] = s_lim[l] < centre[l];
      s_den_mag[l] = s_den_neg[l] ? (centre[l] - s_lim[l]) : (s_lim[l] - centre[l]);
      s_num[l]     = NUM_W'(s_diff[l]) * NUM_W'(PCT_FULL);
    end
  end

  // One restoring-division step per axis
  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      d_shift[l] = {rem_q[l], quo_q[l][NUM_W-1]};
      d_fits[l]  = d_shift[l] >= {1'b0, den_mag_q[l]};
    end
  end

  // Accumulate calibration samples
  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      sum_new[l] = sum_acc[l] + SUM_W'(raw_q[l]);
    end
  end

  // Clamp, sign and saturate the quotients
  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      qclip[l] = (quo_q[l] > NUM_W'(PCT_FULL)) ? (PCT_W-1)'(PCT_FULL) : quo_q[l][PCT_W-2:0];
      pmag[l]  = $signed({1'b0, qclip[l]});
      if (diff_zero_q[l]) begin
        pct[l] = '0;
      end else if (den_zero_q[l]) begin
        pct[l] = above_q[l] ? PCT_W'(PCT_FULL) : -PCT_W'(PCT_FULL);
      end else begin
        pct[l] = den_neg_q[l] ? -pmag[l] : pmag[l];
      end
    end
  end

  // Classify direction; vertical wins ties
  always_comb begin
    logic signed [PCT_W-1:0] ax;
    logic signed [PCT_W-1:0] ay;
    ax      = (pct[0] < 0) ? -pct[0] : pct[0];
    ay      = (pct[1] < 0) ? -pct[1] : pct[1];
    thr_pos = $signed({1'b0, cfg.direction_threshold});
    thr_neg = -thr_pos;
    priority if (pct[1] > thr_pos && pct[1] >= ax) begin
      dir_c = STICK_UP;
    end else if (pct[1] < thr_neg && ay >= ax) begin
      dir_c = STICK_DOWN;
    end else if (pct[0] > thr_pos && ax > ay) begin
      dir_c = STICK_RIGHT;
    end else if (pct[0] < thr_neg && ax > ay) begin
      dir_c = STICK_LEFT;
    end else begin
      dir_c = STICK_NEUTRAL;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q   <= kind;
      raw_q[0] <= raw_x;
      raw_q[1] <= raw_y;
    end
  end

  // Calibration accumulators and centres
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count <= '0;
      latched_q   <= 1'b0;
      for (int l = 0; l < AXES; l++) begin
        sum_acc[l] <= '0;
        centre[l]  <= CENTRE_RST;
      end
    end else if (cmd.calib_step) begin
      latched_q <= run_done;
      if (run_done) begin
        calib_count <= '0;
        for (int l = 0; l < AXES; l++) begin
          sum_acc[l] <= '0;
          centre[l]  <= RAW_W'(sum_new[l] / CALIB_SAMPLES);
        end
      end else begin
        calib_count <= calib_count + CNT_W'(1);
        for (int l = 0; l < AXES; l++) begin
          sum_acc[l] <= sum_new[l];
        end
      end
    end
  end

  // Load and advance the division lanes
  always_ff @(posedge clk) begin
    for (int l = 0; l < AXES; l++) begin
      if (cmd.setup) begin
        above_q[l]     <= s_above[l];
        diff_zero_q[l] <= (s_diff[l] == '0);
        den_zero_q[l]  <= (s_den_mag[l] == '0);
        den_neg_q[l]   <= s_den_neg[l];
        den_mag_q[l]   <= s_den_mag[l];
        rem_q[l]       <= '0;
        quo_q[l]       <= s_num[l];
      end else if (cmd.div_step) begin
        rem_q[l] <= d_fits[l] ? RAW_W'(d_shift[l] - {1'b0, den_mag_q[l]})
                              : d_shift[l][RAW_W-1:0];
        quo_q[l] <= {quo_q[l][NUM_W-2:0], d_fits[l]};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (kind_q == KIND_CALIB) begin
        x_pct          <= '0;
        y_pct          <= '0;
        direction      <= STICK_NEUTRAL;
        centre_latched <= latched_q;
      end else begin
        x_pct          <= pct[0];
        y_pct          <= pct[1];
        direction      <= dir_c;
        centre_latched <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/joystick_centre_scale_direction.sv
// Top level of the two-axis joystick conditioner.
//
// Channels: "sample" takes one transaction per pair of raw 8-bit readings
// (kind 0 = calibration, 1 = position); "result" returns exactly one
// transaction per sample. Both use valid/ready; a transaction moves on a
// rising edge with valid and ready high. Registers (upper_limit at 0x0,
// lower_limit at 0x4, direction_threshold at 0x8) sit on the APB port.
//
// A calibration sample passes through the branch and finish steps; a position
// sample passes through branch, divide and finish. Only one sample is in
// flight: the next is taken once the previous result has been loaded. The
// position result comes from a restoring divider, one quotient bit per cycle
// over 15 bits, with one lane per axis working side by side.
//
// Reset (synchronous, rst high) clears the accumulators and the sample count,
// sets both centres to 160 and loads the register defaults.
// A stalled receiver holds the result register; the next sample is still
// taken and processed, then waits in the finish step until the result
// register frees up.
module joystick_centre_scale_direction (
  input  logic                         clk,
  input  logic                         rst,
  jcsd_in_if.sink                      sample,
  jcsd_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jcsd_pkg::ADDR_W-1:0]  paddr,
  input  logic [jcsd_pkg::DATA_W-1:0]  pwdata,
  output logic [jcsd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import jcsd_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  jcsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jcsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  jcsd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg),
    .kind           (sample.kind),
    .raw_x          (sample.raw_x),
    .raw_y          (sample.raw_y),
    .x_pct          (result.x_pct),
    .y_pct          (result.y_pct),
    .direction      (result.direction),
    .centre_latched (result.centre_latched)
  );

  // One sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample taken while another is in flight");

  // A latched centre only comes with a calibration result
  a_calib_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.centre_latched) |->
      (result.x_pct == '0 && result.y_pct == '0 &&
       result.direction == STICK_NEUTRAL))
    else $error("calibration result carries a deflection");

  // Percents stay within full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      ($signed(result.x_pct) <= 8'sd100 && $signed(result.x_pct) >= -8'sd100 &&
       $signed(result.y_pct) <= 8'sd100 && $signed(result.y_pct) >= -8'sd100))
    else $error("percent out of range");

  // Up and down agree with the sign of the vertical percent
  a_dir_sign: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.direction == STICK_UP || result.direction == STICK_DOWN)) |->
      ((result.direction == STICK_UP) == ($signed(result.y_pct) > 8'sd0)))
    else $error("vertical direction disagrees with y percent");

endmodule

FILE: tb/sv/joystick_centre_scale_direction_tb.sv
// Self-checking testbench for the joystick centre, scale and direction block.
`timescale 1ns / 100ps

module joystick_centre_scale_direction_tb;
  import jcsd_pkg::*;

  // Result of one sample as the block should return it
  typedef struct {
    logic signed [PCT_W-1:0] x_pct;
    logic signed [PCT_W-1:0] y_pct;
    dir_t                    dir;
    logic                    latched;
  } joy_result_t;

  // Hand-written expectation that travels with a sample until it is taken
  typedef struct {
    bit          has_want;
    joy_result_t want;
  } typed_entry_t;

  typedef enum {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  // One row of the directed stimulus table
  typedef struct {
    step_kind_t       step;
    logic             kind;
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    bit               has_want;
    joy_result_t      want;
    reg_idx_t         reg_sel;
    logic [RAW_W-1:0] reg_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  jcsd_in_if  sample_ch ();
  jcsd_out_if result_ch ();

  joystick_centre_scale_direction dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of registers and calibration state
  logic [RAW_W-1:0] upper_q    = UPPER_RST;
  logic [RAW_W-1:0] lower_q    = LOWER_RST;
  logic [THR_W-1:0] thresh_q   = THRESH_RST;
  logic [RAW_W-1:0] centre_x_q = CENTRE_RST;
  logic [RAW_W-1:0] centre_y_q = CENTRE_RST;
  int               sum_x      = 0;
  int               sum_y      = 0;
  int               calib_n    = 0;

  joy_result_t  expected_q[$];
  typed_entry_t typed_q[$];
  dir_row_t     directed_rows[$];
  joy_result_t  no_want;
  int           fail_count   = 0;
  int           burst_left   = 0;
  bit           no_gaps      = 1'b0;
  bit           hold_request = 1'b0;

  always #10 clk = ~clk;

  // Timeout
  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Scale one axis to a signed percent, truncated toward zero and clamped
  function automatic logic signed [PCT_W-1:0] scale_to_percent(logic [RAW_W-1:0] raw,
                                                             logic [RAW_W-1:0] centre);
    int r, c, num, den, q;
    r = int'(raw);
    c = int'(centre);
    if (r > c) begin
      num = PCT_FULL * (r - c);
      den = int'(upper_q) - c;
      q = (den == 0) ? PCT_FULL : num / den;
    end else begin
      num = PCT_FULL * (c - r);
      den = int'(lower_q) - c;
      if (den == 0) q = (num == 0) ? 0 : -PCT_FULL;
      else q = num / den;
    end
    if (q > PCT_FULL) q = PCT_FULL;
    else if (q < -PCT_FULL) q = -PCT_FULL;
    return q[PCT_W-1:0];
  endfunction

  // Classify direction; vertical wins ties, horizontal needs a strict lead
  function automatic dir_t pick_direction(int xp, int yp);
    int t, ax, ay;
    t = int'(thresh_q);
    ax = (xp < 0) ? -xp : xp;
    ay = (yp < 0) ? -yp : yp;
    if (yp > t && yp >= ax) return STICK_UP;
    if (yp < -t && ay >= ax) return STICK_DOWN;
    if (xp > t && ax > ay) return STICK_RIGHT;
    if (xp < -t && ax > ay) return STICK_LEFT;
    return STICK_NEUTRAL;
  endfunction

  // Advance the predictor by one accepted sample and return its result
  function automatic joy_result_t predict_result(logic kind, logic [RAW_W-1:0] rx,
                                                 logic [RAW_W-1:0] ry);
    joy_result_t r;
    r.x_pct = '0;
    r.y_pct = '0;
    r.dir = STICK_NEUTRAL;
    r.latched = 1'b0;
    if (kind == KIND_CALIB) begin
      sum_x += int'(rx);
      sum_y += int'(ry);
      calib_n++;
      if (calib_n >= CALIB_SAMPLES) begin
        centre_x_q = RAW_W'(sum_x / CALIB_SAMPLES);
        centre_y_q = RAW_W'(sum_y / CALIB_SAMPLES);
        sum_x = 0;
        sum_y = 0;
        calib_n = 0;
        r.latched = 1'b1;
      end
    end else begin
      r.x_pct = scale_to_percent(rx, centre_x_q);
      r.y_pct = scale_to_percent(ry, centre_y_q);
      r.dir = pick_direction(int'(r.x_pct), int'(r.y_pct));
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Check results against the oldest expectation, then log new samples
  always @(posedge clk) begin : result_check
    joy_result_t  want;
    joy_result_t  model;
    typed_entry_t entry;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: x=%0d y=%0d dir=%0d latched=%0b",
                                 result_ch.x_pct, result_ch.y_pct,
                                 result_ch.direction, result_ch.centre_latched));
        end else begin
          want = expected_q.pop_front();
          if (result_ch.x_pct !== want.x_pct || result_ch.y_pct !== want.y_pct ||
              result_ch.direction !== want.dir ||
              result_ch.centre_latched !== want.latched) begin
            note_failure($sformatf(
              "mismatch: want x=%0d y=%0d dir=%0d lat=%0b, got x=%0d y=%0d dir=%0d lat=%0b",
              want.x_pct, want.y_pct, want.dir, want.latched,
              result_ch.x_pct, result_ch.y_pct, result_ch.direction,
              result_ch.centre_latched));
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        entry.has_want = 1'b0;
        if (typed_q.size() != 0) entry = typed_q.pop_front();
        model = predict_result(sample_ch.kind, sample_ch.raw_x, sample_ch.raw_y);
        if (entry.has_want) expected_q.push_back(entry.want);
        else expected_q.push_back(model);
      end
    end
  end

  // Receiver: switch stall pattern now and then, hold off once for a long stretch
  initial begin : result_sink
    int mode;
    int mode_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 9) < 7);
        2: result_ch.ready <= ($urandom_range(0, 9) < 3);
        default: result_ch.ready <= ((mode_left % 8) < 5);
      endcase
    end
  end

  // Offer one sample, hold it until the transaction, then maybe leave a gap
  task automatic send_sample(input logic kind, input logic [RAW_W-1:0] rx,
                             input logic [RAW_W-1:0] ry, input bit has_want,
                             input joy_result_t want);
    typed_entry_t entry;
    entry.has_want = has_want;
    entry.want = want;
    typed_q.push_back(entry);
    sample_ch.valid <= 1'b1;
    sample_ch.kind  <= kind;
    sample_ch.raw_x <= rx;
    sample_ch.raw_y <= ry;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        sample_ch.valid <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(15, 45)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [RAW_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = $urandom();
    data[RAW_W-1:0] = value;
    if (idx == REG_THRESH) data[THR_W] = 1'($urandom_range(0, 1));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UPPER:  upper_q = data[RAW_W-1:0];
      REG_LOWER:  lower_q = data[RAW_W-1:0];
      REG_THRESH: thresh_q = data[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [RAW_W-1:0] up, input logic [RAW_W-1:0] lo,
                            input logic [RAW_W-1:0] thr);
    wait_drained();
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    write_reg(REG_THRESH, thr);
  endtask

  // Directed table rows
  function automatic void row_sample(logic kind, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
    dir_row_t row;
    row.step = STEP_SAMPLE;
    row.kind = kind;
    row.rx = rx;
    row.ry = ry;
    row.has_want = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_typed(logic kind, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                                    int xp, int yp, dir_t d);
    dir_row_t row;
    row.step = STEP_SAMPLE;
    row.kind = kind;
    row.rx = rx;
    row.ry = ry;
    row.has_want = 1'b1;
    row.want.x_pct = PCT_W'(xp);
    row.want.y_pct = PCT_W'(yp);
    row.want.dir = d;
    row.want.latched = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_write(reg_idx_t idx, logic [RAW_W-1:0] value);
    dir_row_t row;
    row.step = STEP_WRITE;
    row.reg_sel = idx;
    row.reg_val = value;
    directed_rows.push_back(row);
  endfunction

  // Calibration reading spread around a base value
  function automatic logic [RAW_W-1:0] near_value(int base, int jit);
    int v;
    v = base + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[RAW_W-1:0];
  endfunction

  // Position reading biased toward the centre, the limits and the rails
  function automatic logic [RAW_W-1:0] pick_reading(logic [RAW_W-1:0] centre);
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return centre;
      3: return near_value(int'(centre), 3);
      4: return upper_q;
      5: return lower_q;
      default: return RAW_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random phase: full calibration runs, broken runs and bursts of positions
  task automatic run_phase(input int n_items);
    int sent, len, base, jit, i;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          case ($urandom_range(0, 3))
            0: base = 0;
            1: base = 255;
            default: base = $urandom_range(0, 255);
          endcase
          jit = $urandom_range(0, 15);
          for (i = 0; i < CALIB_SAMPLES; i++)
            send_sample(KIND_CALIB, near_value(base, jit), near_value(base, jit), 1'b0, no_want);
          sent += CALIB_SAMPLES;
        end
        2: begin
          len = $urandom_range(1, 10);
          for (i = 0; i < len; i++)
            send_sample(KIND_CALIB, RAW_W'($urandom_range(0, 255)),
                        RAW_W'($urandom_range(0, 255)), 1'b0, no_want);
          sent += len;
        end
        default: begin
          len = $urandom_range(1, 12);
          for (i = 0; i < len; i++)
            send_sample(KIND_POS, pick_reading(centre_x_q), pick_reading(centre_y_q),
                        1'b0, no_want);
          sent += len;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [RAW_W-1:0] v;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.kind = KIND_CALIB;
    sample_ch.raw_x = '0;
    sample_ch.raw_y = '0;
    no_want.x_pct = '0;
    no_want.y_pct = '0;
    no_want.dir = STICK_NEUTRAL;
    no_want.latched = 1'b0;

    // Defaults after reset: centre 160, limits 245 and 75, threshold 40
    row_typed(KIND_POS, 8'd160, 8'd160, 0, 0, STICK_NEUTRAL);
    row_typed(KIND_POS, 8'd245, 8'd160, 100, 0, STICK_RIGHT);
    row_typed(KIND_POS, 8'd75, 8'd160, -100, 0, STICK_LEFT);
    row_typed(KIND_POS, 8'd160, 8'd245, 0, 100, STICK_UP);
    row_typed(KIND_POS, 8'd160, 8'd75, 0, -100, STICK_DOWN);
    row_typed(KIND_POS, 8'd255, 8'd255, 100, 100, STICK_UP);
    row_typed(KIND_POS, 8'd0, 8'd0, -100, -100, STICK_DOWN);
    row_typed(KIND_CALIB, 8'd0, 8'd0, 0, 0, STICK_NEUTRAL);
    row_typed(KIND_CALIB, 8'd255, 8'd255, 0, 0, STICK_NEUTRAL);
    row_sample(KIND_POS, 8'd200, 8'd120);
    row_sample(KIND_POS, 8'd168, 8'd100);
    // Threshold extremes
    row_write(REG_THRESH, 8'd0);
    row_sample(KIND_POS, 8'd161, 8'd160);
    row_typed(KIND_POS, 8'd160, 8'd160, 0, 0, STICK_NEUTRAL);
    row_write(REG_THRESH, 8'd100);
    row_typed(KIND_POS, 8'd255, 8'd160, 100, 0, STICK_NEUTRAL);
    row_typed(KIND_POS, 8'd0, 8'd255, -100, 100, STICK_NEUTRAL);
    // Both limits on the centre: zero divisor
    row_write(REG_UPPER, 8'd160);
    row_write(REG_LOWER, 8'd160);
    row_typed(KIND_POS, 8'd161, 8'd159, 100, -100, STICK_NEUTRAL);
    row_typed(KIND_POS, 8'd160, 8'd160, 0, 0, STICK_NEUTRAL);
    row_write(REG_THRESH, 8'd40);
    row_typed(KIND_POS, 8'd255, 8'd0, 100, -100, STICK_DOWN);
    // Limits on the wrong side of the centre
    row_write(REG_UPPER, 8'd100);
    row_write(REG_LOWER, 8'd255);
    row_sample(KIND_POS, 8'd200, 8'd100);
    row_sample(KIND_POS, 8'd255, 8'd0);
    row_sample(KIND_POS, 8'd0, 8'd255);
    // Full-range limits
    row_write(REG_UPPER, 8'd255);
    row_write(REG_LOWER, 8'd0);
    row_typed(KIND_POS, 8'd255, 8'd0, 100, -100, STICK_DOWN);
    row_typed(KIND_POS, 8'd255, 8'd255, 100, 100, STICK_UP);
    row_typed(KIND_CALIB, 8'd128, 8'd64, 0, 0, STICK_NEUTRAL);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].step == STEP_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_sample(directed_rows[i].kind, directed_rows[i].rx, directed_rows[i].ry,
                    directed_rows[i].has_want, directed_rows[i].want);
      end
    end

    // Random phases over several register settings
    set_limits(UPPER_RST, LOWER_RST, RAW_W'(THRESH_RST));
    run_phase(90);
    set_limits(8'd255, 8'd0, 8'd0);
    run_phase(90);
    set_limits(8'd0, 8'd255, 8'd100);
    run_phase(90);
    set_limits(RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
               RAW_W'($urandom_range(0, 100)));
    run_phase(90);
    v = centre_x_q;
    set_limits(v, v, RAW_W'($urandom_range(0, 100)));
    run_phase(90);
    // Long receiver hold while samples keep coming
    set_limits(RAW_W'($urandom_range(128, 255)), RAW_W'($urandom_range(0, 127)),
               RAW_W'($urandom_range(0, 100)));
    hold_request <= 1'b1;
    no_gaps = 1'b1;
    run_phase(90);
    no_gaps = 1'b0;
    set_limits(8'd255, 8'd0, 8'd100);
    run_phase(90);
    set_limits(RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
               RAW_W'($urandom_range(0, 100)));
    run_phase(90);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
